### hdl/conv_patch_range_estimator_unit_defines.svh
// Assertion helpers for the range estimator.
`ifndef CONV_PATCH_RANGE_ESTIMATOR_UNIT_DEFINES_SVH
`define CONV_PATCH_RANGE_ESTIMATOR_UNIT_DEFINES_SVH

// Checked on every rising clk edge outside reset.
`define CPRE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Antecedent in one cycle, consequent in the next.
`define CPRE_ASSERT_NEXT(lbl, ante, cons, msg) \
    `CPRE_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

### hdl/cpre_pkg.sv
package cpre_pkg;

    localparam int FEATURE_DEPTH_DEF    = 4096;
    localparam int MAX_OUT_CHANNELS_DEF = 64;
    localparam int MAX_KERNEL           = 15;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 28;

    localparam logic [CFG_IDX_W-1:0] CFG_IN_WIDTH     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IN_HEIGHT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IN_CHANNELS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_WIDTH    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_HEIGHT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_CHANNELS = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SHAPE = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_SHAPE   = 3'd7;

    localparam logic ACT_STATS   = 1'b0;
    localparam logic ACT_FEATURE = 1'b1;

    typedef struct packed {
        logic              action;
        logic [5:0]        channel;
        logic signed [7:0] ch_mean;
        logic signed [7:0] ch_spread;
        logic signed [7:0] feature_value;
        logic              last_feature;
    } in_item_t;

    typedef struct packed {
        logic [5:0]         out_channel;
        logic signed [31:0] range_min;
        logic signed [31:0] range_max;
        logic               last_channel;
    } out_item_t;

    typedef struct packed {
        logic load_stats;
        logic load_feat;
        logic pos_init;
        logic row_next;
        logic pos_next;
        logic tap_init;
        logic tap_row_next;
        logic tap_col_next;
        logic pix_calc;
        logic addr_calc;
        logic ch_read;
        logic sqrt_go;
        logic chan_init;
        logic chan_mul;
        logic chan_upd;
        logic out_next;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic pos_done;
        logic row_done;
        logic tap_rows_done;
        logic tap_cols_done;
        logic tap_in_bounds;
        logic ch_done;
        logic sqrt_done;
        logic chan_done;
    } stat_t;

endpackage

### hdl/conv_patch_range_estimator_unit.sv
// Convolution patch range estimator.
// Command channel: an item beat is taken at a rising edge with start high and busy
// low. Action 0 writes one output channel's weight mean/std (busy stays low).
// Action 1 appends one feature element at the running load address; with
// last_feature set it starts the patch walk and busy rises.
// Walk: per sampled position each kernel row and tap is visited; a tap out of bounds
// is skipped, one in bounds reads every input channel. Then the square root unit runs
// and each output channel's range is updated through the table ports; each output
// row ends with a row step.
// Results: then one beat per output channel in ascending order, result_valid low
// between beats, each shown on result for exactly one cycle with result_valid high; the
// receiver cannot stall and must take every beat. last_channel marks the final beat.
// busy falls after the final beat once the controller has left its output-read state;
// load address and first-patch flag are restored then.
// Configuration: cfg_we, cfg_index, cfg_data write a register. The user must write
// only while busy is low; the block itself does not enforce it.
// Reset (rst_n low, async) restores register defaults, empties the load address and
// returns the controller to idle; feature and channel tables hold no reset value.
module conv_patch_range_estimator_unit
#(
    parameter int FEATURE_DEPTH    = cpre_pkg::FEATURE_DEPTH_DEF,
    parameter int MAX_OUT_CHANNELS = cpre_pkg::MAX_OUT_CHANNELS_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  cpre_pkg::in_item_t              in_item,
    output logic                            result_valid,
    output cpre_pkg::out_item_t             result,
    input  logic                            cfg_we,
    input  logic [cpre_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cpre_pkg::CFG_DATA_W-1:0] cfg_data
);
    import cpre_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // sequencer: owns every state decision
    cpre_ctrl u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .action       (in_item.action),
        .last_feature (in_item.last_feature),
        .stat         (stat),
        .cmd          (cmd),
        .busy         (busy),
        .result_valid (result_valid)
    );

    // stores, walk counters, accumulators, sqrt and range math
    cpre_dp
    #(
        .FEATURE_DEPTH    (FEATURE_DEPTH),
        .MAX_OUT_CHANNELS (MAX_OUT_CHANNELS)
    )
    u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_item),
        .cmd       (cmd),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .stat      (stat),
        .result    (result)
    );

endmodule

### hdl/cpre_sqrt.sv
module cpre_sqrt
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        go,
    input  logic [31:0] radicand,
    output logic        done,
    output logic [15:0] root
);
    // Restoring square root, one result bit per cycle, until all 16 root bits are formed.
    logic        busy_reg;
    logic [3:0]  cnt_reg;
    logic [31:0] val_reg;
    logic [19:0] rem_reg;
    logic [15:0] root_reg;
    logic        done_reg;
    logic [19:0] rem_shift;
    logic [19:0] trial;

    assign rem_shift = {rem_reg[17:0], val_reg[31:30]};
    assign trial     = {2'b00, root_reg, 2'b01};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 4'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (go)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 4'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 4'd1;
                if (cnt_reg == 4'd15)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            val_reg  <= radicand;
            rem_reg  <= 20'd0;
            root_reg <= 16'd0;
        end
        else if (busy_reg)
        begin
            val_reg <= {val_reg[29:0], 2'b00};
            if (rem_shift >= trial)
            begin
                rem_reg  <= rem_shift - trial;
                root_reg <= {root_reg[14:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_shift;
                root_reg <= {root_reg[14:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

### hdl/cpre_ctrl.sv
module cpre_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic          action,
    input  logic          last_feature,
    input  cpre_pkg::stat_t stat,
    output cpre_pkg::cmd_t  cmd,
    output logic          busy,
    output logic          result_valid
);
    import cpre_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_POS_CHECK,
        ST_TAP_INIT,
        ST_TAP_CHECK,
        ST_ADDR,
        ST_CH,
        ST_SQRT_GO,
        ST_SQRT_WAIT,
        ST_CHAN_RD,
        ST_CHAN_MUL,
        ST_CHAN_UPD,
        ST_OUT_RD,
        ST_OUT_SHOW
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (action == ACT_FEATURE)
                    begin
                        cmd.load_feat = 1'b1;
                        if (last_feature)
                        begin
                            cmd.pos_init = 1'b1;
                            state_next   = ST_POS_CHECK;
                        end
                    end
                    else
                    begin
                        cmd.load_stats = 1'b1;
                    end
                end
            end
            ST_POS_CHECK:
            begin
                priority if (stat.pos_done)
                begin
                    cmd.chan_init = 1'b1;
                    state_next    = ST_OUT_RD;
                end
                else if (stat.row_done)
                begin
                    cmd.row_next = 1'b1;
                end
                else
                begin
                    state_next = ST_TAP_INIT;
                end
            end
            ST_TAP_INIT:
            begin
                cmd.tap_init = 1'b1;
                state_next   = ST_TAP_CHECK;
            end
            ST_TAP_CHECK:
            begin
                priority if (stat.tap_rows_done)
                begin
                    state_next = ST_SQRT_GO;
                end
                else if (stat.tap_cols_done)
                begin
                    cmd.tap_row_next = 1'b1;
                end
                else if (stat.tap_in_bounds)
                begin
                    cmd.pix_calc = 1'b1;
                    state_next   = ST_ADDR;
                end
                else
                begin
                    cmd.tap_col_next = 1'b1;
                end
            end
            ST_ADDR:
            begin
                cmd.addr_calc = 1'b1;
                state_next    = ST_CH;
            end
            ST_CH:
            begin
                if (stat.ch_done)
                begin
                    cmd.tap_col_next = 1'b1;
                    state_next       = ST_TAP_CHECK;
                end
                else
                begin
                    cmd.ch_read = 1'b1;
                end
            end
            ST_SQRT_GO:
            begin
                cmd.sqrt_go = 1'b1;
                state_next  = ST_SQRT_WAIT;
            end
            ST_SQRT_WAIT:
            begin
                if (stat.sqrt_done)
                begin
                    cmd.chan_init = 1'b1;
                    state_next    = ST_CHAN_RD;
                end
            end
            ST_CHAN_RD:
            begin
                if (stat.chan_done)
                begin
                    cmd.pos_next = 1'b1;
                    state_next   = ST_POS_CHECK;
                end
                else
                begin
                    state_next = ST_CHAN_MUL;
                end
            end
            ST_CHAN_MUL:
            begin
                cmd.chan_mul = 1'b1;
                state_next   = ST_CHAN_UPD;
            end
            ST_CHAN_UPD:
            begin
                cmd.chan_upd = 1'b1;
                state_next   = ST_CHAN_RD;
            end
            ST_OUT_RD:
            begin
                if (stat.chan_done)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_OUT_SHOW;
                end
            end
            ST_OUT_SHOW:
            begin
                cmd.out_next = 1'b1;
                state_next   = ST_OUT_RD;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = (state_reg == ST_OUT_SHOW);

endmodule

### hdl/cpre_dp.sv
module cpre_dp
#(
    parameter int FEATURE_DEPTH    = cpre_pkg::FEATURE_DEPTH_DEF,
    parameter int MAX_OUT_CHANNELS = cpre_pkg::MAX_OUT_CHANNELS_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  cpre_pkg::in_item_t                 in_item,
    input  cpre_pkg::cmd_t                     cmd,
    input  logic                               cfg_we,
    input  logic [cpre_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cpre_pkg::CFG_DATA_W-1:0]    cfg_data,
    output cpre_pkg::stat_t                    stat,
    output cpre_pkg::out_item_t                result
);
    import cpre_pkg::*;

    localparam int AW = $clog2(FEATURE_DEPTH);
    localparam int CW = (MAX_OUT_CHANNELS > 1) ? $clog2(MAX_OUT_CHANNELS) : 1;

    // configuration
    logic [6:0]  in_width_reg, in_height_reg, out_width_reg, out_height_reg;
    logic [6:0]  out_channels_reg;
    logic [4:0]  in_channels_reg;
    logic [7:0]  window_reg;
    logic [27:0] step_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_width_reg     <= 7'd16;
            in_height_reg    <= 7'd16;
            in_channels_reg  <= 5'd16;
            out_width_reg    <= 7'd16;
            out_height_reg   <= 7'd16;
            out_channels_reg <= 7'd64;
            window_reg       <= 8'h33;
            step_reg         <= 28'h1111111;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_IN_WIDTH:     in_width_reg     <= cfg_data[6:0];
                CFG_IN_HEIGHT:    in_height_reg    <= cfg_data[6:0];
                CFG_IN_CHANNELS:  in_channels_reg  <= cfg_data[4:0];
                CFG_OUT_WIDTH:    out_width_reg    <= cfg_data[6:0];
                CFG_OUT_HEIGHT:   out_height_reg   <= cfg_data[6:0];
                CFG_OUT_CHANNELS: out_channels_reg <= cfg_data[6:0];
                CFG_WINDOW_SHAPE: window_reg       <= cfg_data[7:0];
                CFG_STEP_SHAPE:   step_reg         <= cfg_data;
                default:          ;
            endcase
        end
    end

    logic [3:0] sx, sy, px, py, dx, dy, ss, kw, kh;
    logic [8:0] nch;

    assign sx = step_reg[3:0];
    assign sy = step_reg[7:4];
    assign px = step_reg[11:8];
    assign py = step_reg[15:12];
    assign dx = step_reg[19:16];
    assign dy = step_reg[23:20];
    assign ss = (step_reg[27:24] == 4'd0) ? 4'd1 : step_reg[27:24];
    assign kw = (32'(window_reg[3:0]) > MAX_KERNEL) ? 4'(MAX_KERNEL) : window_reg[3:0];
    assign kh = (32'(window_reg[7:4]) > MAX_KERNEL) ? 4'(MAX_KERNEL) : window_reg[7:4];
    assign nch = (32'(out_channels_reg) > MAX_OUT_CHANNELS) ? 9'(MAX_OUT_CHANNELS)
                                                           : {2'b00, out_channels_reg};

    // position and window walk
    logic [7:0]         ox_reg, oy_reg;
    logic signed [13:0] bx_reg, tx_reg, ty_reg;
    logic signed [13:0] bx_calc, by_calc;
    logic [3:0]         i_reg, j_reg;
    logic [13:0]        pix_reg;
    logic [18:0]        addr_full;
    logic [AW-1:0]      base_reg, load_addr_reg, rd_addr;
    logic [4:0]         ch_reg;
    logic               rd_valid_reg;
    logic signed [7:0]  feat_rd_reg;
    logic signed [15:0] feat_sqr;
    logic signed [31:0] sum_reg;
    logic [31:0]        sq_reg;
    logic               first_reg;

    assign bx_calc = $signed({2'b00, 12'({4'b0000, ox_reg} * {8'd0, sx})})
                   - $signed({10'd0, px});
    assign by_calc = $signed({2'b00, 12'({4'b0000, oy_reg} * {8'd0, sy})})
                   - $signed({10'd0, py});
    assign addr_full = 19'({5'd0, pix_reg} * {14'd0, in_channels_reg});
    assign rd_addr   = base_reg + AW'(ch_reg);
    assign feat_sqr  = feat_rd_reg * feat_rd_reg;

    logic [7:0] feat_mem [FEATURE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (cmd.load_feat)
        begin
            feat_mem[load_addr_reg] <= in_item.feature_value;
        end
        feat_rd_reg <= feat_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_addr_reg <= '0;
            first_reg     <= 1'b1;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= cmd.ch_read;
            if (cmd.finish)
            begin
                load_addr_reg <= '0;
            end
            else if (cmd.load_feat)
            begin
                load_addr_reg <= load_addr_reg + AW'(1);
            end
            if (cmd.finish || cmd.pos_init)
            begin
                first_reg <= 1'b1;
            end
            else if (cmd.pos_next)
            begin
                first_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pos_init)
        begin
            ox_reg <= 8'd0;
            oy_reg <= 8'd0;
        end
        else if (cmd.row_next)
        begin
            ox_reg <= 8'd0;
            oy_reg <= oy_reg + {4'd0, ss};
        end
        else if (cmd.pos_next)
        begin
            ox_reg <= ox_reg + {4'd0, ss};
        end

        if (cmd.tap_init)
        begin
            bx_reg <= bx_calc;
            tx_reg <= bx_calc;
            ty_reg <= by_calc;
            i_reg  <= 4'd0;
            j_reg  <= 4'd0;
        end
        else if (cmd.tap_row_next)
        begin
            i_reg  <= i_reg + 4'd1;
            j_reg  <= 4'd0;
            ty_reg <= ty_reg + $signed({10'd0, dy});
            tx_reg <= bx_reg;
        end
        else if (cmd.tap_col_next)
        begin
            j_reg  <= j_reg + 4'd1;
            tx_reg <= tx_reg + $signed({10'd0, dx});
        end

        if (cmd.pix_calc)
        begin
            pix_reg <= 14'({7'd0, ty_reg[6:0]} * {7'd0, in_width_reg}) + {7'd0, tx_reg[6:0]};
        end
        if (cmd.addr_calc)
        begin
            base_reg <= addr_full[AW-1:0];
            ch_reg   <= 5'd0;
        end
        else if (cmd.ch_read)
        begin
            ch_reg <= ch_reg + 5'd1;
        end

        if (cmd.tap_init)
        begin
            sum_reg <= 32'sd0;
            sq_reg  <= 32'd0;
        end
        else if (rd_valid_reg)
        begin
            sum_reg <= sum_reg + 32'(feat_rd_reg);
            sq_reg  <= sq_reg + {16'd0, 16'(feat_sqr)};
        end
    end

    // square root of the window energy
    logic        sqrt_done;
    logic [15:0] root;

    cpre_sqrt u_sqrt
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (cmd.sqrt_go),
        .radicand (sq_reg),
        .done     (sqrt_done),
        .root     (root)
    );

    // per-channel tables
    logic [8:0]         c_reg;
    logic [CW-1:0]      c_addr;
    logic signed [7:0]  mean_rd_reg, std_rd_reg;
    logic signed [31:0] min_rd_reg, max_rd_reg;
    logic signed [31:0] base_prod_reg, spread_prod_reg;
    logic signed [31:0] lo, hi;
    logic [CW-1:0]      ld_addr;

    logic [7:0]  mean_mem [MAX_OUT_CHANNELS];
    logic [7:0]  std_mem  [MAX_OUT_CHANNELS];
    logic [31:0] min_mem  [MAX_OUT_CHANNELS];
    logic [31:0] max_mem  [MAX_OUT_CHANNELS];

    assign c_addr  = c_reg[CW-1:0];
    assign ld_addr = CW'(in_item.channel);
    assign lo      = base_prod_reg - spread_prod_reg;
    assign hi      = base_prod_reg + spread_prod_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_stats && (32'(in_item.channel) < MAX_OUT_CHANNELS))
        begin
            mean_mem[ld_addr] <= in_item.ch_mean;
            std_mem[ld_addr]  <= in_item.ch_spread;
        end
        if (cmd.chan_upd && (first_reg || (lo < min_rd_reg)))
        begin
            min_mem[c_addr] <= lo;
        end
        if (cmd.chan_upd && (first_reg || (hi > max_rd_reg)))
        begin
            max_mem[c_addr] <= hi;
        end
        mean_rd_reg <= mean_mem[c_addr];
        std_rd_reg  <= std_mem[c_addr];
        min_rd_reg  <= min_mem[c_addr];
        max_rd_reg  <= max_mem[c_addr];

        if (cmd.chan_mul)
        begin
            base_prod_reg   <= 32'(mean_rd_reg) * sum_reg;
            spread_prod_reg <= (32'(std_rd_reg) * $signed({16'd0, root})) <<< 1;
        end

        if (cmd.chan_init)
        begin
            c_reg <= 9'd0;
        end
        else if (cmd.chan_upd || cmd.out_next)
        begin
            c_reg <= c_reg + 9'd1;
        end
    end

    always_comb
    begin
        stat.pos_done      = (oy_reg >= {1'b0, out_height_reg});
        stat.row_done      = (ox_reg >= {1'b0, out_width_reg});
        stat.tap_rows_done = (i_reg >= kh);
        stat.tap_cols_done = (j_reg >= kw);
        stat.tap_in_bounds = !tx_reg[13] && !ty_reg[13]
                           && (tx_reg < $signed({7'd0, in_width_reg}))
                           && (ty_reg < $signed({7'd0, in_height_reg}))
                           && (in_channels_reg != 5'd0);
        stat.ch_done       = (ch_reg >= in_channels_reg);
        stat.sqrt_done     = sqrt_done;
        stat.chan_done     = (c_reg >= nch);
    end

    // no patch visited: report zero range
    assign result.out_channel  = c_reg[5:0];
    assign result.range_min    = first_reg ? 32'sd0 : min_rd_reg;
    assign result.range_max    = first_reg ? 32'sd0 : max_rd_reg;
    assign result.last_channel = ((c_reg + 9'd1) == nch);

endmodule

### hdl/cpre_checker.sv
`include "conv_patch_range_estimator_unit_defines.svh"

module cpre_checker
(
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input cpre_pkg::in_item_t  in_item,
    input logic                result_valid,
    input cpre_pkg::out_item_t result
);
    import cpre_pkg::*;

    `CPRE_ASSERT(a_result_while_busy, result_valid |-> busy, "result beat while idle")
    `CPRE_ASSERT_NEXT(a_stats_no_busy, start && !busy && (in_item.action == ACT_STATS), !busy, "stats load raised busy")
    `CPRE_ASSERT_NEXT(a_last_starts, start && !busy && (in_item.action == ACT_FEATURE) && in_item.last_feature, busy, "last element did not start walk")
    `CPRE_ASSERT_NEXT(a_final_beat, result_valid && result.last_channel, !result_valid, "beat after final channel")
    `CPRE_ASSERT_NEXT(a_mid_beat_busy, result_valid && !result.last_channel, busy, "busy fell before final channel")

endmodule

bind conv_patch_range_estimator_unit cpre_checker u_cpre_checker (.*);
